/* src/tdpa_pkg.sv */
// Shared constants, codes and interface types for the two-direction priority arbiter.
`default_nettype none

package tdpa_pkg;

    // Default sizes handed to the top level parameters.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;

    // Widest stored identifier the design supports.
    localparam int ID_MAX_W  = 16;
    // Width of the identifier reported on the result channel.
    localparam int ID_OUT_W  = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 4;
    localparam int RUN_W     = 4;
    localparam int NUM_QUEUES = 4;
    localparam int Q_W       = 2;

    // Command codes.
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_GRANT  = 1'b1;

    // Direction codes.
    localparam logic DIR_EAST = 1'b0;
    localparam logic DIR_WEST = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GRANT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

    localparam logic [RUN_W-1:0] RUN_MAX     = 4'd15;
    localparam logic [RUN_W-1:0] RUN_ONE     = 4'd1;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 4'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input transfer into the input registers
        logic exec;      // arbitrate or enqueue, update queue state
        logic load;      // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

/* src/two_direction_priority_arbiter_top.sv */
// Top level of the two-direction priority arbiter: controller, datapath and checks.
// Each item passes through capture, queue update with the memory access and result load
// before the next input transfer is taken; a stalled output holds the controller in its
// result state.
// Reset is synchronous and active low: queue pointers, fill counts, run count and grant
// history clear, and the starvation limit returns to two. The queue memory is not cleared.
`default_nettype none

module two_direction_priority_arbiter_top #(
    parameter int QUEUE_DEPTH = tdpa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = tdpa_pkg::ID_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration: starvation limit.
    input  wire                                i_cfg_we,
    input  wire  [tdpa_pkg::CFG_W-1:0]         i_cfg_wdata,
    // Input channel.
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_command,
    input  wire  [tdpa_pkg::ID_OUT_W-1:0]      i_requester_id,
    input  wire                                i_direction,
    input  wire                                i_high_priority,
    // Result channel.
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [tdpa_pkg::STATUS_W-1:0]      o_status,
    output logic [tdpa_pkg::ID_OUT_W-1:0]      o_granted_id,
    output logic                               o_granted_direction,
    output logic                               o_granted_high
);

    // The controller and datapath talk only through these two groups.
    tdpa_pkg::t_dp_cmd  dp_cmd;
    tdpa_pkg::t_dp_stat dp_stat;

    // The controller takes one transfer at a time and walks it through execution
    // and into the output register. The output register lets a new input transfer
    // be taken while the previous result still waits on the result channel.
    tdpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the four queues in a single memory, one region per queue,
    // picks the winner among the queue heads, and keeps the run count that enforces
    // the starvation limit.
    tdpa_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_command           (i_command),
        .i_requester_id      (i_requester_id),
        .i_direction         (i_direction),
        .i_high_priority     (i_high_priority),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_granted_id        (o_granted_id),
        .o_granted_direction (o_granted_direction),
        .o_granted_high      (o_granted_high)
    );

    // A new result is only loaded when the output register is free.
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load |-> dp_stat.out_free)
        else $error("result loaded over a pending result");

    // The controller issues at most one command per cycle.
    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.capture, dp_cmd.exec, dp_cmd.load}))
        else $error("more than one datapath command in a cycle");

    // After an input transfer the block holds off further input until the result is loaded.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && dp_cmd.exec))
        else $error("input transfer not followed by execution");

    // Only a grant carries requester fields; every other result reports zeros.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != tdpa_pkg::ST_GRANT)) |->
            ((o_granted_id == '0) && !o_granted_direction && !o_granted_high))
        else $error("non-grant result carries requester fields");

endmodule

`default_nettype wire

/* src/tdpa_ctrl.sv */
// Controller state machine sequencing capture, execution and result load.
`default_nettype none

module tdpa_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  tdpa_pkg::t_dp_stat   i_stat,
    output tdpa_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_RESULT) && i_stat.out_free;

endmodule

`default_nettype wire

/* src/tdpa_datapath.sv */
// Datapath: four requester queues in one memory, arbitration, run count and output register.
`default_nettype none

module tdpa_datapath #(
    parameter int QUEUE_DEPTH = tdpa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = tdpa_pkg::ID_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tdpa_pkg::t_dp_cmd                  i_cmd,
    output tdpa_pkg::t_dp_stat                 o_stat,
    input  wire                                i_cfg_we,
    input  wire  [tdpa_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire                                i_command,
    input  wire  [tdpa_pkg::ID_OUT_W-1:0]      i_requester_id,
    input  wire                                i_direction,
    input  wire                                i_high_priority,
    input  wire                                i_stall,
    output logic                               o_valid,
    output logic [tdpa_pkg::STATUS_W-1:0]      o_status,
    output logic [tdpa_pkg::ID_OUT_W-1:0]      o_granted_id,
    output logic                               o_granted_direction,
    output logic                               o_granted_high
);

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = tdpa_pkg::NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int Q_W       = tdpa_pkg::Q_W;

    // Input registers.
    logic                r_cmd;
    logic [ID_WIDTH-1:0] r_id;
    logic                r_dir;
    logic                r_high;

    // Queue bookkeeping.
    logic [PTR_W-1:0]  r_head [tdpa_pkg::NUM_QUEUES];
    logic [PTR_W-1:0]  r_tail [tdpa_pkg::NUM_QUEUES];
    logic [FILL_W-1:0] r_fill [tdpa_pkg::NUM_QUEUES];

    // Arbitration history and configuration.
    logic                        r_have_last;
    logic                        r_last_dir;
    logic [tdpa_pkg::RUN_W-1:0]  r_run;
    logic [tdpa_pkg::CFG_W-1:0]  r_limit;

    // Queue memory and its registered read port.
    logic [ID_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [ID_WIDTH-1:0] r_rd_data;

    // Result staged between execution and output load.
    logic [tdpa_pkg::STATUS_W-1:0] r_res_status;
    logic                          r_res_dir;
    logic                          r_res_high;

    // Output register.
    logic                          r_out_valid;
    logic [tdpa_pkg::STATUS_W-1:0] r_o_status;
    logic [tdpa_pkg::ID_OUT_W-1:0] r_o_id;
    logic                          r_o_dir;
    logic                          r_o_high;

    logic [tdpa_pkg::ID_MAX_W-1:0] id_wide;
    logic [tdpa_pkg::ID_MAX_W-1:0] rd_wide;
    logic [Q_W-1:0]                q_arr;
    logic [Q_W-1:0]                q_win;
    logic [tdpa_pkg::NUM_QUEUES-1:0] has;
    logic                          east_any;
    logic                          west_any;
    logic                          win_dir;
    logic                          win_high;
    logic                          arr_full;
    logic                          grant_hit;
    logic                          mem_we;
    logic                          mem_re;
    logic [ADDR_W-1:0]             waddr;
    logic [ADDR_W-1:0]             raddr;

    assign id_wide = tdpa_pkg::ID_MAX_W'(i_requester_id);
    assign rd_wide = tdpa_pkg::ID_MAX_W'(r_rd_data);

    always_comb begin
        for (int i = 0; i < tdpa_pkg::NUM_QUEUES; i++) begin
            has[i] = (r_fill[i] != '0);
        end
    end

    // Queue number is direction times two plus the high priority bit.
    assign q_arr    = {r_dir, r_high};
    assign east_any = has[1] | has[0];
    assign west_any = has[3] | has[2];
    assign arr_full = (r_fill[q_arr] == FILL_W'(QUEUE_DEPTH));

    always_comb begin
        if (!east_any) begin
            win_dir = tdpa_pkg::DIR_WEST;
        end else if (!west_any) begin
            win_dir = tdpa_pkg::DIR_EAST;
        end else if (r_have_last && (r_run >= r_limit)) begin
            // The run in one direction is at the limit: serve the other one.
            win_dir = ~r_last_dir;
        end else if (has[1] != has[3]) begin
            win_dir = has[3] ? tdpa_pkg::DIR_WEST : tdpa_pkg::DIR_EAST;
        end else if (r_have_last) begin
            win_dir = ~r_last_dir;
        end else begin
            win_dir = tdpa_pkg::DIR_WEST;
        end
    end

    assign win_high  = win_dir ? has[3] : has[1];
    assign q_win     = {win_dir, win_high};
    assign grant_hit = (r_cmd == tdpa_pkg::CMD_GRANT) && (east_any || west_any);

    assign mem_we = i_cmd.exec && (r_cmd == tdpa_pkg::CMD_ARRIVE) && !arr_full;
    assign mem_re = i_cmd.exec && grant_hit;
    assign waddr  = ADDR_W'(q_arr) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tail[q_arr]);
    assign raddr  = ADDR_W'(q_win) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[q_win]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= r_id;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_id   <= id_wide[ID_WIDTH-1:0];
            r_dir  <= i_direction;
            r_high <= i_high_priority;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tdpa_pkg::NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
            r_have_last <= 1'b0;
            r_last_dir  <= tdpa_pkg::DIR_EAST;
            r_run       <= '0;
        end else begin
            for (int i = 0; i < tdpa_pkg::NUM_QUEUES; i++) begin
                if (mem_we && (q_arr == Q_W'(i))) begin
                    r_tail[i] <= (r_tail[i] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail[i] + 1'b1;
                    r_fill[i] <= r_fill[i] + 1'b1;
                end
                if (mem_re && (q_win == Q_W'(i))) begin
                    r_head[i] <= (r_head[i] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head[i] + 1'b1;
                    r_fill[i] <= r_fill[i] - 1'b1;
                end
            end
            if (mem_re) begin
                if (r_have_last && (win_dir == r_last_dir)) begin
                    if (r_run != tdpa_pkg::RUN_MAX) begin
                        r_run <= r_run + 1'b1;
                    end
                end else begin
                    r_run       <= tdpa_pkg::RUN_ONE;
                    r_last_dir  <= win_dir;
                    r_have_last <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tdpa_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_cmd == tdpa_pkg::CMD_ARRIVE) begin
                r_res_status <= arr_full ? tdpa_pkg::ST_FULL : tdpa_pkg::ST_ENQ;
            end else begin
                r_res_status <= grant_hit ? tdpa_pkg::ST_GRANT : tdpa_pkg::ST_NONE;
            end
            r_res_dir  <= grant_hit & win_dir;
            r_res_high <= grant_hit & win_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= r_res_status;
            r_o_id     <= (r_res_status == tdpa_pkg::ST_GRANT) ?
                          rd_wide[tdpa_pkg::ID_OUT_W-1:0] : '0;
            r_o_dir    <= r_res_dir;
            r_o_high   <= r_res_high;
        end
    end

    assign o_stat.out_free     = !r_out_valid || !i_stall;
    assign o_valid             = r_out_valid;
    assign o_status            = r_o_status;
    assign o_granted_id        = r_o_id;
    assign o_granted_direction = r_o_dir;
    assign o_granted_high      = r_o_high;

endmodule

`default_nettype wire

/* dv/two_direction_priority_arbiter_top_tb.sv */
// Self-checking testbench for the two-direction priority arbiter with starvation limit.
`timescale 1ns / 100ps

module two_direction_priority_arbiter_top_tb;

    import tdpa_pkg::*;

    // The clock runs at 12 ns.
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 8;

    // Each queue holds this many requesters before arrivals are dropped.
    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // The random part runs in phases. Each phase starts with a new starvation
    // limit and its own mix of arrivals and grants.
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int DIRECTED_ROWS = 5;

    // Cycles allowed after the last transfer before the final check, so that
    // the pipeline has certainly gone quiet.
    localparam int SETTLE_CYCLES = 8;

    // Slowest correct run: about 1700 transfers, each one with its own pass through
    // capture, execution and result load, a random sender gap before each burst and a
    // receiver that stalls three quarters of the time. The limit below leaves a wide
    // margin over that.
    localparam int CYCLE_LIMIT = 400000;

    // One result transfer as seen on the output channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_OUT_W-1:0] granted_id;
        logic                granted_dir;
        logic                granted_high;
    } grant_result_t;

    // One line of the directed stimulus. An arrival line that repeats uses
    // consecutive IDs starting at req_id. When has_want is set the expected
    // result is the one typed into the line; otherwise the predictor decides.
    typedef struct packed {
        logic                command;
        logic [ID_OUT_W-1:0] req_id;
        logic                dir;
        logic                high;
        logic [4:0]          repeats;
        logic                has_want;
        grant_result_t       want;
    } stim_row_t;

    // Receiver behavior. The stall pattern switches between these modes at
    // random so that stalls fall on every phase of the block's work.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // Block inputs, all at known values from time zero.
    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                i_cfg_we            = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata         = '0;
    logic                i_valid             = 1'b0;
    logic                i_command           = CMD_ARRIVE;
    logic [ID_OUT_W-1:0] i_requester_id      = '0;
    logic                i_direction         = DIR_EAST;
    logic                i_high_priority     = 1'b0;
    logic                i_stall             = 1'b0;

    // Block outputs.
    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_OUT_W-1:0] o_granted_id;
    logic                o_granted_direction;
    logic                o_granted_high;

    // Arbiter state as the testbench predicts it. Queue number is
    // direction * 2 + priority, the same numbering the block uses.
    logic [ID_OUT_W-1:0] waiting_ids [NUM_QUEUES][DEPTH];
    int                  waiting_head [NUM_QUEUES];
    int                  waiting_fill [NUM_QUEUES];
    logic                granted_before = 1'b0;
    logic                last_dir       = DIR_EAST;
    logic [RUN_W-1:0]    same_dir_run   = '0;
    logic [CFG_W-1:0]    starve_limit   = LIMIT_RESET;

    // Results that the block still owes, oldest first.
    grant_result_t pending_results [$];

    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    two_direction_priority_arbiter_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_command           (i_command),
        .i_requester_id      (i_requester_id),
        .i_direction         (i_direction),
        .i_high_priority     (i_high_priority),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_granted_id        (o_granted_id),
        .o_granted_direction (o_granted_direction),
        .o_granted_high      (o_granted_high)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Runs one transfer through the predicted arbiter state and returns the
    // result the block must produce for it.
    function automatic grant_result_t arbitrate(input logic command, input logic [7:0] req_id,
                                                input logic dir, input logic high);
        grant_result_t res;
        int q;
        int east_q;
        int west_q;
        int win;
        res = '0;
        if (command == CMD_ARRIVE) begin
            q = dir * 2 + high;
            if (waiting_fill[q] >= DEPTH) begin
                // A full queue drops the arrival and leaves all state alone.
                res.status = ST_FULL;
            end else begin
                waiting_ids[q][(waiting_head[q] + waiting_fill[q]) % DEPTH] = req_id;
                waiting_fill[q]++;
                res.status = ST_ENQ;
            end
            return res;
        end

        // Best head in each direction: the high-priority queue comes first.
        east_q = (waiting_fill[1] != 0) ? 1 : (waiting_fill[0] != 0) ? 0 : -1;
        west_q = (waiting_fill[3] != 0) ? 3 : (waiting_fill[2] != 0) ? 2 : -1;
        if (east_q < 0 && west_q < 0) begin
            res.status = ST_NONE;
            return res;
        end

        if (east_q < 0) begin
            win = west_q;
        end else if (west_q < 0) begin
            win = east_q;
        end else if (granted_before && same_dir_run >= starve_limit) begin
            // The current direction has had its run; the other side goes now.
            win = (last_dir == DIR_EAST) ? west_q : east_q;
        end else if (east_q[0] != west_q[0]) begin
            win = east_q[0] ? east_q : west_q;
        end else if (granted_before) begin
            win = (last_dir == DIR_EAST) ? west_q : east_q;
        end else begin
            // Equal priority and no grant so far: west is served first.
            win = west_q;
        end

        res.status       = ST_GRANT;
        res.granted_id   = waiting_ids[win][waiting_head[win]];
        res.granted_dir  = win[1];
        res.granted_high = win[0];
        waiting_head[win] = (waiting_head[win] + 1) % DEPTH;
        waiting_fill[win]--;

        if (granted_before && res.granted_dir == last_dir) begin
            if (same_dir_run < RUN_MAX) begin
                same_dir_run++;
            end
        end else begin
            same_dir_run   = RUN_ONE;
            last_dir       = res.granted_dir;
            granted_before = 1'b1;
        end
        return res;
    endfunction

    // Offers one input transfer and waits for the block to take it. Called at
    // a falling edge and returns at a falling edge. The sender works in bursts:
    // when a burst is used up, valid drops for a random gap, which may be zero
    // so that long stretches without idling also occur.
    task automatic send_item(input logic command, input logic [7:0] req_id,
                             input logic dir, input logic high,
                             input logic has_want, input grant_result_t want);
        grant_result_t predicted;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;

        i_valid         <= 1'b1;
        i_command       <= command;
        i_requester_id  <= req_id;
        i_direction     <= dir;
        i_high_priority <= high;

        // The payload stays put until a rising edge sees the stall low.
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end

        predicted = arbitrate(command, req_id, dir, high);
        pending_results.push_back(has_want ? want : predicted);
        @(negedge i_clk);
    endtask

    // Writes the starvation limit while the block is idle: no transfer is
    // offered, every owed result has arrived and the pipeline has had time
    // to settle. Called and returns at a falling edge.
    task automatic set_starve_limit(input logic [CFG_W-1:0] value);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        starve_limit = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: the stall changes at the falling edge only. Each mode lasts a
    // random number of cycles; one of them never stalls at all.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 99) < 75);
            STALL_PERIODIC: i_stall <= ((cycle_count % 5) < 2);
            default:        i_stall <= 1'b0;
        endcase
    end

    // Result checker: every transfer on the output channel is compared, field
    // by field, with the oldest owed result.
    always @(posedge i_clk) begin
        grant_result_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with none expected: status %0d id %0h",
                         $time, o_status, o_granted_id);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_granted_id !== want.granted_id) begin
                    mismatches++;
                    $display("%0t: granted_id expected %0h actual %0h",
                             $time, want.granted_id, o_granted_id);
                end
                if (o_granted_direction !== want.granted_dir) begin
                    mismatches++;
                    $display("%0t: granted_direction expected %0d actual %0d",
                             $time, want.granted_dir, o_granted_direction);
                end
                if (o_granted_high !== want.granted_high) begin
                    mismatches++;
                    $display("%0t: granted_high expected %0d actual %0d",
                             $time, want.granted_high, o_granted_high);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        stim_row_t        rows [DIRECTED_ROWS];
        logic [CFG_W-1:0] limit;
        int               grant_pct;
        int               west_pct;
        int               high_pct;
        logic             command;
        logic             dir;
        logic             high;

        for (int q = 0; q < NUM_QUEUES; q++) begin
            waiting_head[q] = 0;
            waiting_fill[q] = 0;
        end

        // Directed part, run with the limit left at its reset value of two.
        // A grant into empty queues finds nobody waiting. Sixteen arrivals
        // fill the east high queue, using the lowest IDs, and the next one is
        // dropped. One west low requester then waits behind two east grants:
        // the first grant has no history, so only priority counts, and after
        // the second the run has reached the limit and the low-priority west
        // requester is forced through ahead of the remaining east ones.
        rows[0] = '{CMD_GRANT,  8'h00, DIR_EAST, 1'b0, 5'd1,  1'b1,
                    '{ST_NONE, 8'h00, 1'b0, 1'b0}};
        rows[1] = '{CMD_ARRIVE, 8'h00, DIR_EAST, 1'b1, 5'd16, 1'b1,
                    '{ST_ENQ, 8'h00, 1'b0, 1'b0}};
        rows[2] = '{CMD_ARRIVE, 8'hFF, DIR_EAST, 1'b1, 5'd1,  1'b1,
                    '{ST_FULL, 8'h00, 1'b0, 1'b0}};
        rows[3] = '{CMD_ARRIVE, 8'hFF, DIR_WEST, 1'b0, 5'd1,  1'b1,
                    '{ST_ENQ, 8'h00, 1'b0, 1'b0}};
        // The last grant row carries its unused fields at their high extremes.
        rows[4] = '{CMD_GRANT,  8'hFF, DIR_WEST, 1'b1, 5'd4,  1'b0, '0};

        // Synchronous reset, held for a few cycles and released once.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int k = 0; k < rows[r].repeats; k++) begin
                send_item(rows[r].command, rows[r].req_id + k[7:0], rows[r].dir,
                          rows[r].high, rows[r].has_want, rows[r].want);
            end
        end

        // Random part. The first phases pin the limit to zero, one, the top
        // value and the reset value; later ones pick it at random. One phase
        // leans on arrivals so queues fill and drop, another on grants so the
        // queues run dry and grants find nobody waiting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       limit = 4'd0;
                1:       limit = 4'd1;
                2:       limit = 4'd15;
                3:       limit = LIMIT_RESET;
                default: limit = CFG_W'($urandom_range(0, 15));
            endcase
            case (p)
                2:       grant_pct = 25;
                5:       grant_pct = 75;
                default: grant_pct = $urandom_range(35, 65);
            endcase
            // A lopsided direction mix gives long same-direction runs.
            west_pct = $urandom_range(10, 90);
            high_pct = $urandom_range(20, 80);
            set_starve_limit(limit);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                command = ($urandom_range(0, 99) < grant_pct) ? CMD_GRANT : CMD_ARRIVE;
                dir     = ($urandom_range(0, 99) < west_pct) ? DIR_WEST : DIR_EAST;
                high    = ($urandom_range(0, 99) < high_pct);
                send_item(command, ID_OUT_W'($urandom_range(0, 255)), dir, high, 1'b0, '0);
            end
        end

        // Drain: stop offering, wait for every owed result, then let the
        // pipeline settle before the verdict.
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
